@@ hdl/stai_pkg.sv @@
// ----------------------------------------------------------------------------
// stai_pkg
// Shared types and constants for the stroke-to-angle table interpolator.
// ----------------------------------------------------------------------------
package stai_pkg;

  localparam int unsigned BUCKETS_DEF    = 256;
  localparam int unsigned MAX_POINTS_DEF = 4;

  localparam int unsigned STROKE_W = 24;
  localparam int unsigned ANGLE_W  = 32;
  localparam int unsigned SLOPE_W  = 32;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned POINT_W  = STROKE_W + ANGLE_W + SLOPE_W;

  // quotient = (stroke delta * 2^24) / slope
  localparam int unsigned FRAC_SHIFT = 24;
  localparam int unsigned DIV_NUM_W  = STROKE_W + 1 + FRAC_SHIFT;
  localparam int unsigned DIV_DEN_W  = SLOPE_W;

  // register indexes
  localparam logic REG_TABLE_OFFSET   = 1'b0;
  localparam logic REG_BUCKETS_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    CMD_WR_CAND  = 2'd0,
    CMD_WR_APPX  = 2'd1,
    CMD_SET_CNT  = 2'd2,
    CMD_CONVERT  = 2'd3
  } cmd_e;

  typedef enum logic [11:0] {
    ST_CLEAR     = 12'b000000000001,
    ST_IDLE      = 12'b000000000010,
    ST_CNT       = 12'b000000000100,
    ST_P0        = 12'b000000001000,
    ST_P1        = 12'b000000010000,
    ST_SCAN_ADDR = 12'b000000100000,
    ST_SCAN_CHK  = 12'b000001000000,
    ST_APX_ADDR  = 12'b000010000000,
    ST_APX_CHK   = 12'b000100000000,
    ST_DIV       = 12'b001000000000,
    ST_FIN       = 12'b010000000000,
    ST_OUT       = 12'b100000000000
  } state_e;

  typedef struct packed {
    logic [1:0]                  command;
    logic [7:0]                  bucket;
    logic [1:0]                  slot;
    logic signed [STROKE_W-1:0]  point_stroke;
    logic signed [ANGLE_W-1:0]   point_angle;
    logic signed [SLOPE_W-1:0]   point_slope;
    logic [CNT_W-1:0]            candidate_count;
    logic [CNT_W-1:0]            appendix_count;
    logic signed [STROKE_W-1:0]  stroke_in;
  } in_word_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_out;
    logic                      empty_bucket;
  } out_word_t;

  typedef struct packed {
    logic signed [STROKE_W-1:0] stroke;
    logic signed [ANGLE_W-1:0]  angle;
    logic signed [SLOPE_W-1:0]  slope;
  } point_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num_mag;
    logic [DIV_DEN_W-1:0] den_mag;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot_mag;
  } div_rsp_t;

endpackage

@@ hdl/stai_ram.sv @@
// ----------------------------------------------------------------------------
// stai_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stai_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/stai_div.sv @@
// ----------------------------------------------------------------------------
// stai_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stai_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stai_pkg::div_req_t req_i,
  output stai_pkg::div_rsp_t rsp_o
);

  localparam int unsigned NW = stai_pkg::DIV_NUM_W;
  localparam int unsigned DW = stai_pkg::DIV_DEN_W;
  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] num_q, num_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem_q[DW-1:0], num_q[NW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
      num_d  = req_i.num_mag;
      den_d  = req_i.den_mag;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_d = {quo_q[NW-2:0], fits};
      num_d = {num_q[NW-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quot_mag = quo_q;

endmodule

@@ hdl/stroke_to_angle_table_interp_top.sv @@
// ----------------------------------------------------------------------------
// stroke_to_angle_table_interp_top
// Stroke (Q16.8) to joint angle (Q16.16) through a bucketed piecewise table.
// ----------------------------------------------------------------------------
// Table writes and count writes: accepted in idle, no result word.
// Convert: fetch the counts and the first two points, scan the candidates,
//   fetch an appendix point if needed, run the bit-serial divide when the
//   slope is nonzero, then form and register the result. One word is in
//   flight at a time: no input word is taken until the result is loaded.
// Reset: control clears at once, then a pass over every bucket zeroes the
//   count memory; no input word is taken until it ends. Registers stay usable.
// ----------------------------------------------------------------------------
module stroke_to_angle_table_interp_top #(
  parameter int unsigned BUCKETS    = stai_pkg::BUCKETS_DEF,
  parameter int unsigned MAX_POINTS = stai_pkg::MAX_POINTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  stai_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output stai_pkg::out_word_t out_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned BAW = $clog2(BUCKETS);
  localparam int unsigned PAW = $clog2(BUCKETS * MAX_POINTS);
  localparam int unsigned CW  = stai_pkg::CNT_W;
  localparam int unsigned SW  = stai_pkg::STROKE_W;
  localparam int unsigned PW  = stai_pkg::POINT_W;
  localparam int unsigned NW  = stai_pkg::DIV_NUM_W;

  // ---------------- configuration registers ----------------
  logic signed [15:0] cfg_offset_q;
  logic [8:0]         cfg_biu_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_offset_q <= '0;
      cfg_biu_q    <= 9'd256;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        stai_pkg::REG_TABLE_OFFSET:   cfg_offset_q <= pwdata[15:0];
        stai_pkg::REG_BUCKETS_IN_USE: cfg_biu_q    <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      stai_pkg::REG_TABLE_OFFSET:   prdata = 32'(cfg_offset_q);
      stai_pkg::REG_BUCKETS_IN_USE: prdata = {23'd0, cfg_biu_q};
      default:                      prdata = '0;
    endcase
  end

  // ---------------- state ----------------
  stai_pkg::state_e state_q, state_d;
  logic [BAW-1:0]   clr_q, clr_d;
  logic signed [SW-1:0] s_q, s_d;
  logic [BAW-1:0]   idx_q, idx_d;
  logic [CW-1:0]    nc_q, nc_d, na_q, na_d, i_q, i_d;
  logic signed [SW-1:0] c0_q, c0_d, a0_q, a0_d;
  logic             rev_q, rev_d, arev_q, arev_d;
  logic             neg_q, neg_d;
  logic signed [31:0] pa_q, pa_d;
  logic signed [31:0] res_q, res_d;
  logic             empty_q, empty_d;
  logic             out_load;
  logic             out_valid_q;
  stai_pkg::out_word_t out_word_q;

  logic in_acc;
  assign in_stall_o = (state_q != stai_pkg::ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  // ---------------- memories ----------------
  // Writes happen only on accept in idle or in the reset clear, reads only while converting, so
  // one word at a time keeps read and write of an entry from overlapping.
  logic               pt_wr_ok;
  logic [PAW-1:0]     pt_waddr, pt_raddr;
  logic [PW-1:0]      pt_wdata, cand_rdata, appx_rdata;
  stai_pkg::point_t   cand_pt, appx_pt;
  logic               cnt_we;
  logic [BAW-1:0]     cnt_waddr;
  logic [2*CW-1:0]    cnt_wdata, cnt_rdata;
  logic [CW-1:0]      off;

  assign pt_wr_ok = (32'(in_word_i.bucket) < BUCKETS) && (32'(in_word_i.slot) < MAX_POINTS);
  assign pt_waddr = PAW'(in_word_i.bucket) * PAW'(MAX_POINTS) + PAW'(in_word_i.slot);
  assign pt_wdata = {in_word_i.point_stroke, in_word_i.point_angle, in_word_i.point_slope};
  assign cand_pt  = stai_pkg::point_t'(cand_rdata);
  assign appx_pt  = stai_pkg::point_t'(appx_rdata);

  function automatic logic [CW-1:0] sat_cnt(input logic [CW-1:0] c);
    sat_cnt = (32'(c) > MAX_POINTS) ? CW'(MAX_POINTS) : c;
  endfunction

  always_comb begin
    if (state_q == stai_pkg::ST_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_q;
      cnt_wdata = '0;
    end else begin
      cnt_we    = in_acc && (in_word_i.command == stai_pkg::CMD_SET_CNT)
                  && (32'(in_word_i.bucket) < BUCKETS);
      cnt_waddr = BAW'(in_word_i.bucket);
      cnt_wdata = {sat_cnt(in_word_i.candidate_count), sat_cnt(in_word_i.appendix_count)};
    end
  end

  always_comb begin
    case (state_q)
      stai_pkg::ST_P0:        off = CW'(1);
      stai_pkg::ST_SCAN_ADDR: off = rev_q ? (nc_q - CW'(1) - i_q) : i_q;
      stai_pkg::ST_APX_ADDR:  off = arev_q ? (na_q - CW'(1)) : '0;
      default:                off = '0;
    endcase
  end
  assign pt_raddr = PAW'(idx_q) * PAW'(MAX_POINTS) + PAW'(off);

  stai_ram #(.WIDTH(PW), .DEPTH(BUCKETS * MAX_POINTS)) u_cand_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && pt_wr_ok && (in_word_i.command == stai_pkg::CMD_WR_CAND)),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (pt_raddr),
    .rdata_o (cand_rdata)
  );

  stai_ram #(.WIDTH(PW), .DEPTH(BUCKETS * MAX_POINTS)) u_appx_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && pt_wr_ok && (in_word_i.command == stai_pkg::CMD_WR_APPX)),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (pt_raddr),
    .rdata_o (appx_rdata)
  );

  stai_ram #(.WIDTH(2 * CW), .DEPTH(BUCKETS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (idx_q),
    .rdata_o (cnt_rdata)
  );

  // ---------------- bucket index ----------------
  // integer part truncated toward zero, minus offset, clamped to [0, lim-1]
  logic signed [SW:0]   s_bias;
  logic signed [16:0]   ip;
  logic signed [18:0]   idx_raw, lim_m1, idx_cl;
  logic [13:0]          lim;

  always_comb begin
    s_bias  = (SW+1)'(in_word_i.stroke_in) + (in_word_i.stroke_in[SW-1] ? 25'sd255 : 25'sd0);
    ip      = 17'(s_bias >>> 8);
    idx_raw = 19'(ip) - 19'(cfg_offset_q);
    lim     = (32'(cfg_biu_q) > BUCKETS) ? 14'(BUCKETS) : 14'(cfg_biu_q);
    lim_m1  = $signed({5'd0, lim}) - 19'sd1;
    idx_cl  = (idx_raw > lim_m1) ? lim_m1 : idx_raw;
    if (idx_cl < 19'sd0) idx_cl = '0;
  end

  // ---------------- point evaluation and divider ----------------
  stai_pkg::div_req_t div_req;
  stai_pkg::div_rsp_t div_rsp;
  stai_pkg::point_t   ev_pt;
  logic signed [SW:0] d_diff;
  logic [SW:0]        d_mag;
  logic               ev_go;

  assign ev_pt  = (state_q == stai_pkg::ST_APX_CHK) ? appx_pt : cand_pt;
  assign d_diff = (SW+1)'(ev_pt.stroke) - (SW+1)'(s_q);
  assign d_mag  = d_diff[SW] ? (SW+1)'(-d_diff) : d_diff;

  assign div_req.start   = ev_go && (ev_pt.slope != '0);
  assign div_req.num_mag = {d_mag, {stai_pkg::FRAC_SHIFT{1'b0}}};
  assign div_req.den_mag = ev_pt.slope[31] ? 32'(-ev_pt.slope) : ev_pt.slope;

  stai_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic signed [NW+1:0] q_sgn, diff;
  always_comb begin
    q_sgn = neg_q ? -$signed({2'b00, div_rsp.quot_mag}) : $signed({2'b00, div_rsp.quot_mag});
    diff  = (NW+2)'(pa_q) - q_sgn;
  end

  // ---------------- sequencer ----------------
  logic cand_hit;
  assign cand_hit = neg_q ? (s_q >= cand_pt.stroke) : (s_q <= cand_pt.stroke);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    s_d     = s_q;
    idx_d   = idx_q;
    nc_d    = nc_q;
    na_d    = na_q;
    i_d     = i_q;
    c0_d    = c0_q;
    a0_d    = a0_q;
    rev_d   = rev_q;
    arev_d  = arev_q;
    neg_d   = neg_q;
    pa_d    = pa_q;
    res_d   = res_q;
    empty_d = empty_q;
    ev_go   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      stai_pkg::ST_CLEAR: begin
        clr_d = clr_q + BAW'(1);
        if (clr_q == BAW'(BUCKETS - 1)) state_d = stai_pkg::ST_IDLE;
      end
      stai_pkg::ST_IDLE: begin
        if (in_acc && (in_word_i.command == stai_pkg::CMD_CONVERT)) begin
          s_d     = in_word_i.stroke_in;
          neg_d   = in_word_i.stroke_in[SW-1];
          idx_d   = BAW'(idx_cl);
          state_d = stai_pkg::ST_CNT;
        end
      end
      stai_pkg::ST_CNT: state_d = stai_pkg::ST_P0;
      stai_pkg::ST_P0: begin
        nc_d    = cnt_rdata[2*CW-1:CW];
        na_d    = cnt_rdata[CW-1:0];
        c0_d    = cand_pt.stroke;
        a0_d    = appx_pt.stroke;
        state_d = stai_pkg::ST_P1;
      end
      stai_pkg::ST_P1: begin
        rev_d   = (nc_q >= CW'(2)) && (neg_q ? (c0_q < cand_pt.stroke)
                                              : (c0_q > cand_pt.stroke));
        arev_d  = (na_q >= CW'(2)) && (neg_q ? (a0_q < appx_pt.stroke)
                                              : (a0_q > appx_pt.stroke));
        i_d     = '0;
        empty_d = 1'b0;
        if (nc_q == '0 && na_q == '0) begin
          empty_d = 1'b1;
          res_d   = '0;
          state_d = stai_pkg::ST_OUT;
        end else if (nc_q != '0) begin
          state_d = stai_pkg::ST_SCAN_ADDR;
        end else begin
          state_d = stai_pkg::ST_APX_ADDR;
        end
      end
      stai_pkg::ST_SCAN_ADDR: state_d = stai_pkg::ST_SCAN_CHK;
      stai_pkg::ST_SCAN_CHK: begin
        if (cand_hit) begin
          ev_go = 1'b1;
        end else if (i_q + CW'(1) == nc_q) begin
          if (na_q == '0) begin
            // last scanned entry is the tail of the list: flat angle
            res_d   = cand_pt.angle;
            state_d = stai_pkg::ST_OUT;
          end else begin
            state_d = stai_pkg::ST_APX_ADDR;
          end
        end else begin
          i_d     = i_q + CW'(1);
          state_d = stai_pkg::ST_SCAN_ADDR;
        end
      end
      stai_pkg::ST_APX_ADDR: state_d = stai_pkg::ST_APX_CHK;
      stai_pkg::ST_APX_CHK:  ev_go = 1'b1;
      stai_pkg::ST_DIV: begin
        if (div_rsp.done) state_d = stai_pkg::ST_FIN;
      end
      stai_pkg::ST_FIN: begin
        if (diff[NW+1:31] != {(NW-29){diff[NW+1]}}) begin
          res_d = diff[NW+1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
          res_d = diff[31:0];
        end
        state_d = stai_pkg::ST_OUT;
      end
      stai_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = stai_pkg::ST_IDLE;
        end
      end
      default: state_d = stai_pkg::ST_IDLE;
    endcase

    if (ev_go) begin
      if (ev_pt.slope == '0) begin
        res_d   = ev_pt.angle;
        state_d = stai_pkg::ST_OUT;
      end else begin
        pa_d    = ev_pt.angle;
        neg_d   = d_diff[SW] ^ ev_pt.slope[31];
        state_d = stai_pkg::ST_DIV;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stai_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    idx_q   <= idx_d;
    nc_q    <= nc_d;
    na_q    <= na_d;
    i_q     <= i_d;
    c0_q    <= c0_d;
    a0_q    <= a0_d;
    rev_q   <= rev_d;
    arev_q  <= arev_d;
    neg_q   <= neg_d;
    pa_q    <= pa_d;
    res_q   <= res_d;
    empty_q <= empty_d;
    if (out_load) begin
      out_word_q.angle_out    <= res_q;
      out_word_q.empty_bucket <= empty_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // ---------------- assertions ----------------
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == stai_pkg::ST_DIV))
    else $error("divider finished outside divide wait");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("held result word overwritten");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.empty_bucket) |-> (out_word_o.angle_out == '0))
    else $error("empty bucket with nonzero angle");

endmodule
